// ===== sv/scalar_kalman_filter_macros.svh =====
// Assertion macros used by the checker.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, microcode format and program of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_Q = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_R = 2'd1;

    // Datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_PRED  = 3'd1;
    localparam logic [OP_W-1:0] OP_INNOV = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
    localparam logic [OP_W-1:0] OP_MULK  = 3'd4;
    localparam logic [OP_W-1:0] OP_CORR  = 3'd5;
    localparam logic [OP_W-1:0] OP_VAR   = 3'd6;

    // Jump conditions
    localparam int JMP_W = 2;
    localparam logic [JMP_W-1:0] JMP_NONE  = 2'd0;
    localparam logic [JMP_W-1:0] JMP_SZERO = 2'd1;
    localparam logic [JMP_W-1:0] JMP_LOOP  = 2'd2;

    // Program addresses
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] STEP_PRED  = 3'd0;
    localparam logic [UPC_W-1:0] STEP_INNOV = 3'd1;
    localparam logic [UPC_W-1:0] STEP_ZCHK  = 3'd2;
    localparam logic [UPC_W-1:0] STEP_DIV   = 3'd3;
    localparam logic [UPC_W-1:0] STEP_MULK  = 3'd4;
    localparam logic [UPC_W-1:0] STEP_CORR  = 3'd5;
    localparam logic [UPC_W-1:0] STEP_VAR   = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [JMP_W-1:0] jmp;
        logic [UPC_W-1:0] target;
        logic             cnt_load;
        logic             done;
    } t_uword;

    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
    } t_dp_ctl;

    typedef struct packed {
        logic s_zero;
    } t_dp_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

    // Control store: one word per step
    function automatic t_uword ucode(input logic [UPC_W-1:0] addr);
        t_uword w;
        w        = '0;
        w.op     = OP_NONE;
        w.jmp    = JMP_NONE;
        w.target = STEP_PRED;
        unique case (addr)
            STEP_PRED: begin
                w.op = OP_PRED;
            end
            STEP_INNOV: begin
                w.op       = OP_INNOV;
                w.cnt_load = 1'b1;
            end
            STEP_ZCHK: begin
                // skip the divide when the denominator is zero, gain stays 0
                w.jmp    = JMP_SZERO;
                w.target = STEP_MULK;
            end
            STEP_DIV: begin
                w.op     = OP_DIV;
                w.jmp    = JMP_LOOP;
                w.target = STEP_DIV;
            end
            STEP_MULK: begin
                w.op = OP_MULK;
            end
            STEP_CORR: begin
                w.op = OP_CORR;
            end
            STEP_VAR: begin
                w.op   = OP_VAR;
                w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter, fixed point, run by a microcode sequencer.
// ----------------------------------------------------------------------------
// Each accepted item (measurement, control input) runs a predict and an
// update on the kept estimate and variance and yields one result: new
// estimate, new variance, gain and innovation. One item is worked at a time:
// the sequencer runs predict, innovation, a zero check, the divide loop
// (one gain bit per cycle, FRAC_BITS + 1 gain bits), multiply, correction
// and variance, and takes a new item only once the last step is done;
// when the prior variance and R are both zero the divide is skipped, the
// gain stays zero and the item is done sooner. Results sit in an output
// register, so the next item is accepted while a result still waits; the
// last step of an item holds while that register is full and stalled.
// The input side stalls during reset. Configuration writes are ready
// whenever the block is out of reset and must only be made while the block
// is idle.
module scalar_kalman_filter #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [DATA_WIDTH-1:0]         i_measurement,
    input  logic [DATA_WIDTH-1:0]         i_control_input,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [DATA_WIDTH-1:0]         o_estimate,
    output logic [DATA_WIDTH-1:0]         o_error_variance,
    output logic [FRAC_BITS:0]            o_gain,
    output logic [DATA_WIDTH-1:0]         o_innovation,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_WIDTH-1:0]         i_cfg_data
);
    import skf_pkg::*;

    localparam logic [DATA_WIDTH-1:0] ONE_D = DATA_WIDTH'(1) << FRAC_BITS;

    logic [DATA_WIDTH-1:0] r_q, r_r;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_est, r_out_var, r_out_innov;
    logic [FRAC_BITS:0]    r_out_gain;

    t_dp_ctl               dp_ctl;
    t_dp_stat              dp_stat;
    t_seq_stat             seq_stat;
    logic                  start;
    logic                  hold;
    logic [DATA_WIDTH-1:0] dp_est, dp_var, dp_innov;
    logic [FRAC_BITS:0]    dp_gain;

    // take no item and no register write while in reset
    assign o_in_stall  = seq_stat.busy || !i_rst_n;
    assign start       = i_in_valid && !o_in_stall;
    assign hold        = r_out_valid && i_out_stall;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= ONE_D;
            r_r <= ONE_D;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_Q: r_q <= i_cfg_data;
                CFG_IDX_R: r_r <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    skf_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_hold     (hold),
        .i_dp_stat  (dp_stat),
        .o_dp_ctl   (dp_ctl),
        .o_seq_stat (seq_stat)
    );

    skf_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (dp_ctl),
        .i_measurement   (i_measurement),
        .i_control_input (i_control_input),
        .i_q             (r_q),
        .i_r             (r_r),
        .o_stat          (dp_stat),
        .o_estimate      (dp_est),
        .o_variance_next (dp_var),
        .o_gain          (dp_gain),
        .o_innovation    (dp_innov)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            r_out_est   <= dp_est;
            r_out_var   <= dp_var;
            r_out_gain  <= dp_gain;
            r_out_innov <= dp_innov;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_estimate       = r_out_est;
    assign o_error_variance = r_out_var;
    assign o_gain           = r_out_gain;
    assign o_innovation     = r_out_innov;

endmodule

// ===== sv/skf_seq.sv =====
// ----------------------------------------------------------------------------
// skf_seq
// Microcode sequencer: step counter, control store, loop counter and jumps.
// ----------------------------------------------------------------------------
module skf_seq #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_hold,
    input  skf_pkg::t_dp_stat   i_dp_stat,
    output skf_pkg::t_dp_ctl    o_dp_ctl,
    output skf_pkg::t_seq_stat  o_seq_stat
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic             r_busy, n_busy;
    logic [UPC_W-1:0] r_upc, n_upc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uword           uw;
    logic             fire;

    assign uw   = ucode(r_upc);
    // hold the final step while the output register is full and stalled
    assign fire = r_busy && !(uw.done && i_hold);

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_upc  = STEP_PRED;
        end else if (fire) begin
            if (uw.cnt_load) begin
                n_cnt = CNT_W'(FRAC_BITS);
            end
            unique case (uw.jmp)
                JMP_NONE: begin
                    n_upc = UPC_W'(r_upc + 1'b1);
                end
                JMP_SZERO: begin
                    n_upc = i_dp_stat.s_zero ? uw.target : UPC_W'(r_upc + 1'b1);
                end
                JMP_LOOP: begin
                    if (r_cnt != '0) begin
                        n_cnt = CNT_W'(r_cnt - 1'b1);
                        n_upc = uw.target;
                    end else begin
                        n_upc = UPC_W'(r_upc + 1'b1);
                    end
                end
                default: begin
                    n_upc = UPC_W'(r_upc + 1'b1);
                end
            endcase
            if (uw.done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= STEP_PRED;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
            r_cnt  <= n_cnt;
        end
    end

    assign o_dp_ctl.load   = i_start;
    assign o_dp_ctl.op     = fire ? uw.op : OP_NONE;
    assign o_seq_stat.busy = r_busy;
    assign o_seq_stat.done = fire && uw.done;

endmodule

// ===== sv/skf_dp.sv =====
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: saturating adders, restoring divider step, one shared
// multiplier with a product register, and the filter state.
// ----------------------------------------------------------------------------
module skf_dp #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  skf_pkg::t_dp_ctl      i_ctl,
    input  logic [DATA_WIDTH-1:0] i_measurement,
    input  logic [DATA_WIDTH-1:0] i_control_input,
    input  logic [DATA_WIDTH-1:0] i_q,
    input  logic [DATA_WIDTH-1:0] i_r,
    output skf_pkg::t_dp_stat     o_stat,
    output logic [DATA_WIDTH-1:0] o_estimate,
    output logic [DATA_WIDTH-1:0] o_variance_next,
    output logic [FRAC_BITS:0]    o_gain,
    output logic [DATA_WIDTH-1:0] o_innovation
);
    import skf_pkg::*;

    localparam int D  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int G  = F + 1;
    localparam int PW = G + D + 2;
    localparam logic [G-1:0]  GAIN_ONE = G'(1) << F;
    localparam logic [PW-1:0] HALF_P   = PW'(1) << (F - 1);

    function automatic logic [D-1:0] sat_s(input logic [D+1:0] v);
        logic [2:0] top;
        top = v[D+1:D-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[D-1:0];
        end else if (v[D+1]) begin
            return {1'b1, {(D-1){1'b0}}};
        end else begin
            return {1'b0, {(D-1){1'b1}}};
        end
    endfunction

    // filter state
    logic [D-1:0]  r_x, r_p;
    // per-item working registers
    logic [D-1:0]  r_y, r_u, r_xp, r_pp, r_e;
    logic [D:0]    r_s;
    logic [D+1:0]  r_rem;
    logic [G-1:0]  r_k;
    logic [PW-1:0] r_prod;

    logic [D+1:0]  x_sum, e_sum, x_new, corr;
    logic [D:0]    p_sum, s_sum;
    logic [D-1:0]  pp_sat;
    logic [D+1:0]  s_ext, rem_diff, rem_keep;
    logic          rem_ge;
    logic [G-1:0]  one_mk;
    logic [G:0]    mul_a;
    logic [D:0]    mul_b;
    logic [PW-1:0] prod, mag, mag_rnd, var_rnd;
    logic          neg;
    logic [D:0]    mag_q;

    // predict
    assign x_sum  = {{2{r_x[D-1]}}, r_x} + {{2{r_u[D-1]}}, r_u};
    assign p_sum  = {1'b0, r_p} + {1'b0, i_q};
    assign pp_sat = p_sum[D] ? {D{1'b1}} : p_sum[D-1:0];

    // innovation and denominator
    assign e_sum = {{2{r_y[D-1]}}, r_y} - {{2{r_xp[D-1]}}, r_xp};
    assign s_sum = {1'b0, r_pp} + {1'b0, i_r};

    // one quotient bit per step, kept remainder always below the divisor
    assign s_ext    = {1'b0, r_s};
    assign rem_ge   = (r_rem >= s_ext);
    assign rem_diff = r_rem - s_ext;
    assign rem_keep = rem_ge ? rem_diff : r_rem;

    // shared multiplier
    assign one_mk = GAIN_ONE - r_k;
    assign mul_a  = (i_ctl.op == OP_MULK) ? {1'b0, r_k} : {1'b0, one_mk};
    assign mul_b  = (i_ctl.op == OP_MULK) ? {r_e[D-1], r_e} : {1'b0, r_pp};
    assign prod   = PW'($signed(mul_a) * $signed(mul_b));

    // correction: round magnitude, halves away from zero
    assign neg     = r_prod[PW-1];
    assign mag     = neg ? (~r_prod + 1'b1) : r_prod;
    assign mag_rnd = mag + HALF_P;
    assign mag_q   = mag_rnd[F +: D+1];
    assign corr    = neg ? ~{1'b0, mag_q} + 1'b1 : {1'b0, mag_q};
    assign x_new   = {{2{r_xp[D-1]}}, r_xp} + corr;

    // variance: product is nonnegative and never exceeds the prior
    assign var_rnd = r_prod + HALF_P;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_p <= '0;
        end else begin
            if (i_ctl.op == OP_CORR) begin
                r_x <= sat_s(x_new);
            end
            if (i_ctl.op == OP_VAR) begin
                r_p <= var_rnd[F +: D];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_y <= i_measurement;
            r_u <= i_control_input;
        end
        unique case (i_ctl.op)
            OP_PRED: begin
                r_xp <= sat_s(x_sum);
                r_pp <= pp_sat;
            end
            OP_INNOV: begin
                r_e   <= sat_s(e_sum);
                r_s   <= s_sum;
                r_rem <= {2'b00, r_pp};
                r_k   <= '0;
            end
            OP_DIV: begin
                r_rem <= {rem_keep[D:0], 1'b0};
                r_k   <= {r_k[G-2:0], rem_ge};
            end
            OP_MULK, OP_CORR: begin
                r_prod <= prod;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.s_zero   = (r_s == '0);
    assign o_estimate      = r_x;
    assign o_variance_next = var_rnd[F +: D];
    assign o_gain          = r_k;
    assign o_innovation    = r_e;

endmodule

// ===== sv/skf_checker.sv =====
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks of the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_macros.svh"

module skf_checker #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_WIDTH-1:0] o_estimate,
    input logic [DATA_WIDTH-1:0] o_error_variance,
    input logic [FRAC_BITS:0]    o_gain
);
    localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // an accepted item keeps the input side busy
    `SKF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

    // a new result only appears after an item was in work
    `SKF_ASSERT_SAME(a_result_from_item, $rose(o_out_valid), $past(o_in_stall), "result without item in work")

    // gain stays within zero to one, and a full gain leaves no variance
    `SKF_ASSERT_SAME(a_gain_range, o_out_valid, o_gain <= GAIN_ONE, "gain above one")
    `SKF_ASSERT_SAME(a_full_gain_var, o_out_valid && o_gain == GAIN_ONE, o_error_variance == '0, "variance left at full gain")

    // a stalled result holds
    `SKF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_estimate) && $stable(o_gain), "stalled result changed")

endmodule

bind scalar_kalman_filter skf_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_skf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_estimate       (o_estimate),
    .o_error_variance (o_error_variance),
    .o_gain           (o_gain)
);
